FILE: design/mpzr_pkg.sv
package mpzr_pkg;

   // Row store geometry.
   localparam int MAX_WIDTH = 2048;
   localparam int COL_W = $clog2(MAX_WIDTH);

   // Field widths.
   localparam int PIXEL_W = 16;
   localparam int IMG_WIDTH_W = 12;

   // Width used for row-length compares; it covers both the register and MAX_WIDTH.
   localparam int LEN_W = (COL_W + 1 > IMG_WIDTH_W) ? COL_W + 1 : IMG_WIDTH_W;

   // Configuration port.
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W = IMG_WIDTH_W;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_WIDTH = 1'b0,
      CSR_DECODE_MODE = 1'b1
   } csr_index_type;

   localparam logic [IMG_WIDTH_W-1:0] IMAGE_WIDTH_RESET = 12'd1500;

   typedef logic [PIXEL_W-1:0] pixel_type;

   // Control flags that go with a request into the prediction logic.
   typedef struct packed {
      logic first_row;
      logic col_zero;
      logic decode_mode;
   } pred_ctl_type;

endpackage

FILE: design/mpzr_req_if.sv
interface mpzr_req_if;
   logic                   valid;
   logic                   ready;
   mpzr_pkg::pixel_type    sample_value;
   logic                   image_start;

   modport source (output valid, output sample_value, output image_start, input ready);
   modport sink (input valid, input sample_value, input image_start, output ready);
endinterface

FILE: design/mpzr_rsp_if.sv
interface mpzr_rsp_if;
   logic                   valid;
   logic                   ready;
   mpzr_pkg::pixel_type    result_value;

   modport source (output valid, output result_value, input ready);
   modport sink (input valid, input result_value, output ready);
endinterface

FILE: design/med_predict_zigzag_residual_core.sv
// Median-edge predictor with zigzag residual mapping for 16-bit pixels in raster
// order. In encode mode each request carries a pixel and the response is its
// zigzag-mapped prediction residual; in decode mode each request carries a mapped
// residual and the response is the reconstructed pixel. Every request gives exactly
// one response. The block takes one request per cycle while responses are taken. An
// accepted request is registered into the prediction stage as the pixel above is
// read from the one-row store (a RAM with a registered read port); that stage forms
// the prediction, where the left neighbor of the next pixel is fed back through one
// clamp-and-add path, and registers the result as the response. Set image_start on
// the first pixel of each image; it restarts the row and column count but does not
// clear the row store. Write image_width and decode_mode only while no request is in
// flight. A width of zero acts as one, and a width beyond the row store size acts as
// that size. After reset the row store is not cleared and needs no clearing pass;
// entries are always written before they are read for a stream of whole rows.
module med_predict_zigzag_residual_core (
   input  logic                                 clock,
   input  logic                                 reset,
   mpzr_req_if.sink                             req_bus,
   mpzr_rsp_if.source                           rsp_bus,
   input  logic                                 csr_write_enable,
   input  logic [mpzr_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [mpzr_pkg::CSR_DATA_W-1:0]      csr_write_data
);

   localparam int COL_W = mpzr_pkg::COL_W;
   localparam int LEN_W = mpzr_pkg::LEN_W;
   localparam int PW = mpzr_pkg::PIXEL_W;

   // Configuration registers.
   logic [mpzr_pkg::IMG_WIDTH_W-1:0] width_ff, width_in;
   logic                             decode_ff, decode_in;

   // Raster position tracked at request acceptance.
   logic [COL_W-1:0] column_ff, column_in;
   logic             first_row_ff, first_row_in;

   // Prediction stage.
   logic                s1_valid_ff, s1_valid_in;
   mpzr_pkg::pixel_type s1_sample_ff, s1_sample_in;
   logic [COL_W-1:0]    s1_col_ff, s1_col_in;
   logic                s1_first_ff, s1_first_in;
   logic                bypass_ff, bypass_in;
   mpzr_pkg::pixel_type bypass_data_ff, bypass_data_in;

   // Neighbor pixels.
   mpzr_pkg::pixel_type left_ff, left_in;
   mpzr_pkg::pixel_type upleft_ff, upleft_in;

   // Response register.
   logic                rsp_valid_ff, rsp_valid_in;
   mpzr_pkg::pixel_type rsp_value_ff, rsp_value_in;

   logic                   accept;
   logic                   advance;
   logic [COL_W-1:0]       req_col;
   logic                   req_first;
   logic [LEN_W-1:0]       width_ext;
   logic [LEN_W-1:0]       eff_width;
   logic [LEN_W-1:0]       col_next;
   logic                   wrap;
   mpzr_pkg::pixel_type    ram_rd_data;
   mpzr_pkg::pixel_type    up;
   mpzr_pkg::pixel_type    pixel;
   mpzr_pkg::pixel_type    result;
   mpzr_pkg::pred_ctl_type pred_ctl;

   // Handshake: the prediction stage moves on whenever the response register is free or its response is taken.
   assign advance = s1_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !s1_valid_ff || advance;
   assign accept = req_bus.valid && req_bus.ready;
   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.result_value = rsp_value_ff;

   // Column of the incoming request and the wrap decision for the next one.
   always_comb begin
      req_col = req_bus.image_start ? '0 : column_ff;
      req_first = req_bus.image_start || first_row_ff;
      width_ext = LEN_W'(width_ff);
      if (width_ff == '0) begin
         eff_width = LEN_W'(1);
      end else if (width_ext > LEN_W'(mpzr_pkg::MAX_WIDTH)) begin
         eff_width = LEN_W'(mpzr_pkg::MAX_WIDTH);
      end else begin
         eff_width = width_ext;
      end
      col_next = LEN_W'(req_col) + LEN_W'(1);
      wrap = col_next >= eff_width;
   end

   // Previous row of pixels.
   mpzr_ram #(
      .WIDTH(PW),
      .DEPTH(mpzr_pkg::MAX_WIDTH)
   ) u_row_store (
      .clock   (clock),
      .wr_en   (advance),
      .wr_addr (s1_col_ff),
      .wr_data (pixel),
      .rd_en   (accept),
      .rd_addr (req_col),
      .rd_data (ram_rd_data)
   );

   // The pixel above comes from the write in flight when a one-pixel row reads it back.
   assign up = bypass_ff ? bypass_data_ff : ram_rd_data;

   assign pred_ctl.first_row = s1_first_ff;
   assign pred_ctl.col_zero = (s1_col_ff == '0);
   assign pred_ctl.decode_mode = decode_ff;

   mpzr_predict u_predict (
      .ctl          (pred_ctl),
      .sample_value (s1_sample_ff),
      .left         (left_ff),
      .up           (up),
      .upleft       (upleft_ff),
      .pixel        (pixel),
      .result       (result)
   );

   // Next-state logic.
   always_comb begin
      width_in = width_ff;
      decode_in = decode_ff;
      if (csr_write_enable) begin
         case (csr_index)
            mpzr_pkg::CSR_IMAGE_WIDTH: width_in = csr_write_data;
            mpzr_pkg::CSR_DECODE_MODE: decode_in = csr_write_data[0];
            default: ;
         endcase
      end

      column_in = column_ff;
      first_row_in = first_row_ff;
      s1_valid_in = s1_valid_ff;
      s1_sample_in = s1_sample_ff;
      s1_col_in = s1_col_ff;
      s1_first_in = s1_first_ff;
      bypass_in = bypass_ff;
      bypass_data_in = bypass_data_ff;
      if (accept) begin
         column_in = wrap ? '0 : col_next[COL_W-1:0];
         first_row_in = wrap ? 1'b0 : req_first;
         s1_valid_in = 1'b1;
         s1_sample_in = req_bus.sample_value;
         s1_col_in = req_col;
         s1_first_in = req_first;
         bypass_in = advance && (s1_col_ff == req_col);
         bypass_data_in = pixel;
      end else if (advance) begin
         s1_valid_in = 1'b0;
         bypass_in = 1'b0;
      end

      left_in = left_ff;
      upleft_in = upleft_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      if (advance) begin
         left_in = pixel;
         upleft_in = up;
         rsp_valid_in = 1'b1;
         rsp_value_in = result;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= mpzr_pkg::IMAGE_WIDTH_RESET;
         decode_ff <= 1'b0;
         column_ff <= '0;
         first_row_ff <= 1'b1;
         s1_valid_ff <= 1'b0;
         bypass_ff <= 1'b0;
         left_ff <= '0;
         upleft_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         width_ff <= width_in;
         decode_ff <= decode_in;
         column_ff <= column_in;
         first_row_ff <= first_row_in;
         s1_valid_ff <= s1_valid_in;
         bypass_ff <= bypass_in;
         left_ff <= left_in;
         upleft_ff <= upleft_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      s1_sample_ff <= s1_sample_in;
      s1_col_ff <= s1_col_in;
      s1_first_ff <= s1_first_in;
      bypass_data_ff <= bypass_data_in;
      rsp_value_ff <= rsp_value_in;
   end

`ifndef SYNTHESIS
   // An image start leaves the position at column one of the first row, or wrapped.
   assert property (@(posedge clock) disable iff (reset)
      accept && req_bus.image_start |=>
         (first_row_ff && column_ff == COL_W'(1)) || (!first_row_ff && column_ff == '0))
      else $error("position after image start is wrong");

   // A request leaving the prediction stage always lands in the response register.
   assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("prediction result lost");

   // With both stages full and the response stalled, no request is taken.
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && rsp_valid_ff && !rsp_bus.ready |-> !req_bus.ready)
      else $error("request accepted into a full pipeline");

   // The bypass only serves a request held in the prediction stage.
   assert property (@(posedge clock) disable iff (reset)
      bypass_ff |-> s1_valid_ff)
      else $error("bypass set without a request in flight");

   // The tracked column never leaves the row store.
   assert property (@(posedge clock) disable iff (reset)
      LEN_W'(column_ff) < LEN_W'(mpzr_pkg::MAX_WIDTH))
      else $error("column index out of range");
`endif

endmodule

FILE: design/mpzr_ram.sv
module mpzr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2048
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // One write port and one registered read port; a read returns the old data
   // when it hits the address being written in the same cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

FILE: design/mpzr_predict.sv
module mpzr_predict (
   input  mpzr_pkg::pred_ctl_type   ctl,
   input  mpzr_pkg::pixel_type      sample_value,
   input  mpzr_pkg::pixel_type      left,
   input  mpzr_pkg::pixel_type      up,
   input  mpzr_pkg::pixel_type      upleft,
   output mpzr_pkg::pixel_type      pixel,
   output mpzr_pkg::pixel_type      result
);

   localparam int PW = mpzr_pkg::PIXEL_W;

   always_comb begin
      logic [PW-1:0]  lo;
      logic [PW-1:0]  hi;
      logic [PW:0]    sum;
      logic [PW:0]    c_lo;
      logic [PW:0]    c_hi;
      logic [PW:0]    gradient;
      logic [PW-1:0]  med;
      logic [PW-1:0]  pred;
      logic [PW-1:0]  half;
      logic [PW-1:0]  recon;
      logic [PW-1:0]  residual;
      logic [PW-1:0]  dbl;
      logic [PW-1:0]  mapped;

      // Median edge detector: a+b-c clamped between left and up.
      lo = (left < up) ? left : up;
      hi = (left < up) ? up : left;
      sum = {1'b0, left} + {1'b0, up};
      c_lo = {1'b0, upleft} + {1'b0, lo};
      c_hi = {1'b0, upleft} + {1'b0, hi};
      gradient = sum - {1'b0, upleft};
      if (sum < c_lo) begin
         med = lo;
      end else if (sum > c_hi) begin
         med = hi;
      end else begin
         med = gradient[PW-1:0];
      end

      // Border handling: origin, first row and column zero.
      if (ctl.first_row) begin
         pred = ctl.col_zero ? '0 : left;
      end else if (ctl.col_zero) begin
         pred = up;
      end else begin
         pred = med;
      end

      // Decode: undo the zigzag map and add the prediction, modulo 2^16.
      half = {1'b0, sample_value[PW-1:1]};
      if (sample_value[0]) begin
         recon = pred - (half + PW'(1));
      end else begin
         recon = pred + half;
      end

      // Encode: wrap the residual to 16 bits and zigzag map it.
      residual = sample_value - pred;
      dbl = {residual[PW-2:0], 1'b0};
      mapped = residual[PW-1] ? ~dbl : dbl;

      pixel = ctl.decode_mode ? recon : sample_value;
      result = ctl.decode_mode ? recon : mapped;
   end

endmodule
